// ===== design/pcc_pkg.sv =====
`default_nettype none

package pcc_pkg;

  localparam int unsigned SEGMENTS_DEF = 3;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned T_W          = FRAC_BITS + 2;
  // row of a point inside its bank: index / 3 for any IDX_W-bit index
  localparam int unsigned ROW_W        = $clog2(((2 ** IDX_W) - 1) / 3 + 1);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BANK_0 = 2'd0,
    BANK_1 = 2'd1,
    BANK_2 = 2'd2
  } bank_e;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [2:0]       vec3_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FRAC_BITS:0]   weight_t;

  typedef struct packed {
    bank_e            bank;
    logic [ROW_W-1:0] row;
  } slot_t;

  // point index -> (index mod 3, index div 3), a small constant table
  function automatic slot_t slot_of(logic [IDX_W-1:0] idx);
    slot_t res;
    res = '{bank: BANK_0, row: '0};
    for (int i = 0; i < 2 ** IDX_W; i++) begin
      if (idx == IDX_W'(i)) begin
        res.bank = bank_e'(2'(i % 3));
        res.row  = ROW_W'(i / 3);
      end
    end
    return res;
  endfunction

  // signed coordinate times unsigned weight, floored by FRAC_BITS, kept to 32 bits
  function automatic coord_t mul_shift(coord_t a, weight_t w);
    logic signed [COORD_W+FRAC_BITS+1:0] prod;
    prod = $signed(a) * $signed({1'b0, w});
    return prod[FRAC_BITS +: COORD_W];
  endfunction

endpackage

`default_nettype wire

// ===== design/pcc_if.sv =====
`default_nettype none

interface pcc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [pcc_pkg::IDX_W-1:0]       point_index;
  logic signed [pcc_pkg::COORD_W-1:0] load_x;
  logic signed [pcc_pkg::COORD_W-1:0] load_y;
  logic signed [pcc_pkg::COORD_W-1:0] load_z;
  logic signed [pcc_pkg::T_W-1:0]  curve_param;

  modport source (
    output valid, kind, point_index, load_x, load_y, load_z, curve_param,
    input  ready
  );
  modport sink (
    input  valid, kind, point_index, load_x, load_y, load_z, curve_param,
    output ready
  );
endinterface

interface pcc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pcc_pkg::COORD_W-1:0] pos_x;
  logic signed [pcc_pkg::COORD_W-1:0] pos_y;
  logic signed [pcc_pkg::COORD_W-1:0] pos_z;

  modport source (
    output valid, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/piecewise_cubic_curve_eval.sv =====
`default_nettype none

// channel | dir | payload                                          | handshake
// in_i    | in  | kind, point_index, load_x/y/z, curve_param      | valid/ready
// out_o   | out | pos_x, pos_y, pos_z                              | valid/ready
//
// One item per cycle while in_i.ready is high. A load item writes its point at
// the accept edge and gives no result. An evaluate item runs seven register
// stages (memory read, then multiply and add for each of three lerp levels).
// Point storage is three banks of rows (index mod 3) with two read ports on
// bank 0. Reset clears only the valid bits; the point banks are not cleared.
// Each stage moves when the one after it is free, so in_i.ready drops only
// when all seven stages hold an item.

module piecewise_cubic_curve_eval #(
  parameter int unsigned SEGMENTS = pcc_pkg::SEGMENTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pcc_in_if.sink     in_i,
  pcc_out_if.source  out_o
);
  import pcc_pkg::*;

  localparam int unsigned Points = 3 * SEGMENTS + 1;
  localparam int unsigned Rows   = SEGMENTS + 1;
  localparam int unsigned AddrW  = $clog2(SEGMENTS + 1);
  localparam int unsigned ScaleW = FRAC_BITS + AddrW;
  localparam int unsigned Stages = 7;
  localparam weight_t     One    = {1'b1, {FRAC_BITS{1'b0}}};

  // point banks: bank k holds points 3*row + k
  vec3_t bank0_mem [Rows];
  vec3_t bank1_mem [Rows];
  vec3_t bank2_mem [Rows];

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  logic             in_acc, eval_acc, load_acc;
  logic             t_le0, t_ge1, clamp;
  logic [ScaleW-1:0] scaled;
  logic [AddrW-1:0] seg, rd_a_addr, rd_b_addr;
  frac_t            s_in;
  slot_t            wr_slot;
  logic [AddrW-1:0] wr_row;
  vec3_t            wr_data;

  vec3_t rd0a_q, rd0b_q, rd1_q, rd2_q;
  logic  clamp0_q;
  frac_t s_q [5];

  vec3_t op   [4];
  vec3_t ta1_q [3];
  vec3_t tb1_q [3];
  vec3_t l1_q  [3];
  vec3_t ta2_q [2];
  vec3_t tb2_q [2];
  vec3_t l2_q  [2];
  vec3_t ta3_q, tb3_q, res_q;

  // ---------------------------------------------------------------- input decode
  always_comb begin
    in_acc   = in_i.valid && in_i.ready;
    eval_acc = in_acc && (in_i.kind == KIND_EVAL);
    load_acc = in_acc && (in_i.kind == KIND_LOAD)
               && (32'(in_i.point_index) < 32'(Points));

    t_le0 = in_i.curve_param[T_W-1] || (in_i.curve_param == '0);
    t_ge1 = !in_i.curve_param[T_W-1] && (|in_i.curve_param[T_W-2:FRAC_BITS]);
    clamp = t_le0 || t_ge1;

    scaled = ScaleW'(in_i.curve_param[FRAC_BITS-1:0]) * ScaleW'(SEGMENTS);
    seg    = scaled[ScaleW-1:FRAC_BITS];
    s_in   = clamp ? '0 : scaled[FRAC_BITS-1:0];

    if (t_le0) begin
      rd_a_addr = '0;
    end else if (t_ge1) begin
      rd_a_addr = AddrW'(SEGMENTS);
    end else begin
      rd_a_addr = seg;
    end
    rd_b_addr = seg + AddrW'(1);

    wr_slot = slot_of(in_i.point_index);
    wr_row  = AddrW'(wr_slot.row);
    wr_data = {in_i.load_z, in_i.load_y, in_i.load_x};
  end

  // ---------------------------------------------------------------- stall chain
  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || out_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= eval_acc;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      case (wr_slot.bank)
        BANK_0:  bank0_mem[wr_row] <= wr_data;
        BANK_1:  bank1_mem[wr_row] <= wr_data;
        BANK_2:  bank2_mem[wr_row] <= wr_data;
        default: ;
      endcase
    end
    if (eval_acc) begin
      rd0a_q   <= bank0_mem[rd_a_addr];
      rd0b_q   <= bank0_mem[rd_b_addr];
      rd1_q    <= bank1_mem[seg];
      rd2_q    <= bank2_mem[seg];
      clamp0_q <= clamp;
    end
  end

  // on a clamped item every operand is the end point and s is zero
  always_comb begin
    if (clamp0_q) begin
      op[0] = rd0a_q;
      op[1] = rd0a_q;
      op[2] = rd0a_q;
      op[3] = rd0a_q;
    end else begin
      op[0] = rd0a_q;
      op[1] = rd1_q;
      op[2] = rd2_q;
      op[3] = rd0b_q;
    end
  end

  // ---------------------------------------------------------------- lerp levels
  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      s_q[0] <= s_in;
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        s_q[k] <= s_q[k-1];
      end
    end
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          ta1_q[j][c] <= mul_shift(op[j][c], One - {1'b0, s_q[0]});
          tb1_q[j][c] <= mul_shift(op[j+1][c], {1'b0, s_q[0]});
        end
      end
    end
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          l1_q[j][c] <= ta1_q[j][c] + tb1_q[j][c];
        end
      end
    end
    if (en[3]) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          ta2_q[j][c] <= mul_shift(l1_q[j][c], One - {1'b0, s_q[2]});
          tb2_q[j][c] <= mul_shift(l1_q[j+1][c], {1'b0, s_q[2]});
        end
      end
    end
    if (en[4]) begin
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < 3; c++) begin
          l2_q[j][c] <= ta2_q[j][c] + tb2_q[j][c];
        end
      end
    end
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        ta3_q[c] <= mul_shift(l2_q[0][c], One - {1'b0, s_q[4]});
        tb3_q[c] <= mul_shift(l2_q[1][c], {1'b0, s_q[4]});
      end
    end
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        res_q[c] <= ta3_q[c] + tb3_q[c];
      end
    end
  end

  assign out_o.valid = v_q[Stages-1];
  assign out_o.pos_x = res_q[0];
  assign out_o.pos_y = res_q[1];
  assign out_o.pos_z = res_q[2];

`ifndef SYNTHESIS
  // a load item never enters the pipeline
  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.kind == KIND_LOAD) |=> !v_q[0])
    else $error("load item entered the evaluate pipeline");

  // input is held off only when every stage is occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v_q))
    else $error("input stalled while a stage was empty");

  // clamped items must carry a zero local parameter
  a_clamp_s0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && clamp0_q) |-> (s_q[0] == '0))
    else $error("clamped item with nonzero local parameter");

  // a stalled result stays in the last stage
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Stages-1] && !out_o.ready) |=> v_q[Stages-1])
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_piecewise_cubic_curve_eval.sv =====
`timescale 1ns / 1ps

module tb_piecewise_cubic_curve_eval;
  import pcc_pkg::*;

  localparam int SEG      = SEGMENTS_DEF;
  localparam int NPTS     = 3 * SEG + 1;
  localparam int T_ONE    = 1 << FRAC_BITS;
  localparam int N_RAND   = 1250;
  localparam int HOLD_CYC = 80;
  localparam int LIMIT    = 200000;

  // directed control points, packed as {z, y, x}
  localparam vec3_t P0 = {32'h00000000, 32'h80000000, 32'h7fffffff};
  localparam vec3_t P1 = {32'hffffffff, 32'h7fffffff, 32'h80000000};
  localparam vec3_t P2 = {32'h12345678, 32'hfffe0000, 32'h00010000};
  localparam vec3_t P3 = {32'h80000000, 32'h7fffffff, 32'h7fffffff};
  localparam vec3_t P4 = {32'h00000001, 32'h80000000, 32'h80000000};
  localparam vec3_t P5 = {32'hfffffffe, 32'h00000000, 32'h7fffffff};
  localparam vec3_t P6 = {32'h00c80000, 32'hff380000, 32'h00640000};
  localparam vec3_t P7 = {32'h7fffffff, 32'h80000000, 32'h00000000};
  localparam vec3_t P8 = {32'hdeadbeef, 32'h01234567, 32'h89abcdef};
  localparam vec3_t P9 = {32'hffffffff, 32'h00000001, 32'h80000000};
  localparam vec3_t ONES = {32'hffffffff, 32'hffffffff, 32'hffffffff};
  localparam vec3_t ALT  = {32'h55555555, 32'haaaaaaaa, 32'h55555555};

  typedef struct packed {
    kind_e                  kind;
    logic [IDX_W-1:0]       idx;
    vec3_t                  pt;
    logic signed [T_W-1:0]  t;
    logic                   fixed_res;  // expected point typed in the table
    vec3_t                  res;
  } req_t;

  logic clk_i;
  logic rst_ni;

  pcc_in_if  in_bus ();
  pcc_out_if out_bus ();

  piecewise_cubic_curve_eval u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  vec3_t ctrl_pts [NPTS];
  vec3_t curve_q [$];
  req_t  dir_q [$];
  int    errs;
  int    n_done;
  bit    calm;
  bit    hold_go;
  int    cycle_cnt;
  vec3_t got;
  vec3_t want;
  int    ax;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic req_t mk_row(kind_e kind, logic [IDX_W-1:0] idx, vec3_t pt,
                                  logic signed [T_W-1:0] t, logic fixed_res, vec3_t res);
    req_t r;
    r.kind      = kind;
    r.idx       = idx;
    r.pt        = pt;
    r.t         = t;
    r.fixed_res = fixed_res;
    r.res       = res;
    return r;
  endfunction

  // (1-s)*a + s*b, each term floored by FRAC_BITS, sum wraps to 32 bits
  function automatic coord_t blend(coord_t a, coord_t b, longint s);
    longint wa;
    longint wb;
    wa = (longint'(T_ONE) - s) * longint'($signed(a));
    wb = s * longint'($signed(b));
    return coord_t'((wa >>> FRAC_BITS) + (wb >>> FRAC_BITS));
  endfunction

  function automatic vec3_t curve_at(logic signed [T_W-1:0] t);
    vec3_t  res;
    longint prod;
    longint seg;
    longint s;
    int     base;
    int     c;
    coord_t e, f, g, h, k;
    if (t <= 0) begin
      res = ctrl_pts[0];
    end else if (t >= T_ONE) begin
      res = ctrl_pts[NPTS-1];
    end else begin
      prod = longint'(t) * SEG;
      seg  = prod >>> FRAC_BITS;
      s    = prod & (T_ONE - 1);
      if (seg > SEG - 1) seg = SEG - 1;
      base = int'(seg) * 3;
      for (c = 0; c < 3; c++) begin
        e      = blend(ctrl_pts[base][c], ctrl_pts[base+1][c], s);
        f      = blend(ctrl_pts[base+1][c], ctrl_pts[base+2][c], s);
        g      = blend(ctrl_pts[base+2][c], ctrl_pts[base+3][c], s);
        h      = blend(e, f, s);
        k      = blend(f, g, s);
        res[c] = blend(h, k, s);
      end
    end
    return res;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return coord_t'(int'($urandom_range(400000)) - 200000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // offer one item, wait for the accept edge, then update the point table or queue the expected point
  task automatic offer_item(req_t r);
    while (!calm && $urandom_range(99) < 31) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= r.kind;
    in_bus.point_index <= r.idx;
    in_bus.load_x      <= r.pt[0];
    in_bus.load_y      <= r.pt[1];
    in_bus.load_z      <= r.pt[2];
    in_bus.curve_param <= r.t;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (r.kind == KIND_LOAD) begin
      if (r.idx < NPTS) ctrl_pts[r.idx] = r.pt;
    end else begin
      curve_q.push_back(r.fixed_res ? r.res : curve_at(r.t));
    end
  endtask

  // stimulus
  initial begin
    req_t r;
    int   w;
    errs    = 0;
    n_done  = 0;
    calm    = 1'b0;
    hold_go = 1'b0;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.kind        <= KIND_LOAD;
    in_bus.point_index <= '0;
    in_bus.load_x      <= '0;
    in_bus.load_y      <= '0;
    in_bus.load_z      <= '0;
    in_bus.curve_param <= '0;

    // every point is loaded before the first evaluate
    dir_q.push_back(mk_row(KIND_LOAD, 4'd0, P0, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd1, P1, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd2, P2, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd3, P3, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd4, P4, 18'sh3ffff, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd5, P5, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd6, P6, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd7, P7, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd8, P8, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'd9, P9, '0, 1'b0, '0));
    // out of range slots: dropped, the end points must survive
    dir_q.push_back(mk_row(KIND_LOAD, 4'd10, ONES, '0, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_LOAD, 4'hf, ALT, 18'sh3ffff, 1'b0, '0));
    // clamped ends
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sh00000, 1'b1, P0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sh20000, 1'b1, P0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sh3ffff, 1'b1, P0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sh10000, 1'b1, P9));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sh1ffff, 1'b1, P9));
    // interior, segment edges
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd1, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd21845, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd21846, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'hf, ONES, 18'sd32768, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd43690, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd43691, 1'b0, '0));
    dir_q.push_back(mk_row(KIND_EVAL, 4'd0, '0, 18'sd65535, 1'b0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) offer_item(dir_q[i]);

    while (n_done < N_RAND) begin
      calm = (n_done >= 500 && n_done < 700);
      if (n_done == 300) hold_go = 1'b1;
      r.fixed_res = 1'b0;
      r.res       = '0;
      r.pt        = {pick_coord(), pick_coord(), pick_coord()};
      r.t         = T_W'($urandom);
      if ($urandom_range(3) == 0) begin
        r.kind = KIND_LOAD;
        r.idx  = ($urandom_range(7) == 0) ? IDX_W'($urandom_range(15, NPTS))
                                          : IDX_W'($urandom_range(NPTS - 1));
      end else begin
        r.kind = KIND_EVAL;
        r.idx  = IDX_W'($urandom);
        case ($urandom_range(7))
          0: r.t = T_W'($urandom);
          1: r.t = -T_W'($urandom_range(T_ONE * 2));
          2: r.t = T_W'($urandom_range(T_ONE * 2 - 1, T_ONE));
          3: begin
            // near a segment boundary
            w   = (T_ONE * int'($urandom_range(1, SEG - 1))) / SEG;
            r.t = T_W'(w + int'($urandom_range(3)) - 1);
          end
          default: r.t = T_W'($urandom_range(T_ONE - 1, 1));
        endcase
      end
      offer_item(r);
      if (!(r.kind == KIND_LOAD && r.idx >= NPTS)) n_done++;
    end
    in_bus.valid <= 1'b0;
    calm = 1'b0;

    w = 0;
    while (curve_q.size() != 0 && w < 5000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (20) @(posedge clk_i);
    if (curve_q.size() != 0) begin
      $display("%0t: %0d expected points never came out", $time, curve_q.size());
      errs++;
    end
    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // output side: random back-pressure, one long hold-off
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_bus.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYC; hold_cnt++) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = {out_bus.pos_z, out_bus.pos_y, out_bus.pos_x};
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h", $time, got[0], got[1], got[2]);
        errs++;
      end else begin
        want = curve_q.pop_front();
        for (ax = 0; ax < 3; ax++) begin
          if (got[ax] !== want[ax]) begin
            $display("%0t: pos axis %0d expected %h got %h", $time, ax, want[ax], got[ax]);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/pcc_pkg.sv
design/pcc_if.sv
design/piecewise_cubic_curve_eval.sv
verif/tb_piecewise_cubic_curve_eval.sv
